@@ sv/ogha_pkg.sv @@
package ogha_pkg;

	// grid size defaults
	localparam int GRID_ROWS_DEF = 500;
	localparam int GRID_COLS_DEF = 400;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADING_COS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADING_SIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_NORTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_EAST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_OFFSET  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_METER = 3'd5;

	localparam logic signed [15:0] HEADING_COS_RST = 16'sd16384;
	localparam logic [15:0]        CPM_RST         = 16'd853;

	// vehicle area limits, 1/256 m
	localparam logic signed [15:0] VN_LIMIT = 16'sd19200;
	localparam logic signed [14:0] VE_LIMIT = 15'sd15360;

	// item fields
	localparam int RC_W    = 9;
	localparam int COUNT_W = 8;
	localparam int STAT_W  = 2;

	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_COUNTED   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SATURATED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OUTSIDE   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_READ      = 2'd3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	// datapath widths
	localparam int F_W         = 17;
	localparam int MUL_W       = 18;
	localparam int ROT_W       = 34;
	localparam int SPLIT       = 17;
	localparam int ACC_W       = 50;
	localparam int CELL_W      = 22;
	localparam int SCALE_SHIFT = 30;

	localparam logic signed [ACC_W-1:0] SCALE_BIAS =
		ACC_W'((64'sd1 <<< SCALE_SHIFT) - 64'sd1);
	localparam logic signed [MUL_W-1:0] MUL_POS_Q14 = 18'sd16384;
	localparam logic signed [MUL_W-1:0] MUL_ONE     = 18'sd1;

	// shared multiply-accumulate control
	typedef enum logic [1:0] {
		MAC_FIRST,
		MAC_ADD,
		MAC_SUB,
		MAC_SHADD
	} mac_kind_t;

	typedef struct packed {
		logic                     en;
		mac_kind_t                kind;
		logic signed [MUL_W-1:0]  a;
		logic signed [MUL_W-1:0]  b;
	} mac_op_t;

endpackage

@@ sv/occupancy_grid_hit_accumulator.sv @@
// sequence: a point goes through the rotation, scaling, range, address and read
//   states; it leaves at the range check when outside the grid, at idle when the
//   vehicle is out of area; a cell read starts at range, leaves there beyond the grid
// throughput: one item at a time; the 18x18 multiply-accumulate unit is used up to 12
//   times per point, so a new item is taken only once the previous result is loaded
// reset: arst_n clears control and configuration, then the grid is zeroed one cell
//   per cycle, GRID_ROWS*GRID_COLS cells (200000 by default), with in_ready low
module occupancy_grid_hit_accumulator #(
	parameter int GRID_ROWS = ogha_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = ogha_pkg::GRID_COLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// configuration writes
	input  logic                                cfg_we,
	input  logic [ogha_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ogha_pkg::CFG_W-1:0]          cfg_data,

	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic signed [15:0]                  point_forward,
	input  logic signed [15:0]                  point_lateral,
	input  logic [ogha_pkg::RC_W-1:0]           read_row,
	input  logic [ogha_pkg::RC_W-1:0]           read_col,

	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ogha_pkg::STAT_W-1:0]         status,
	output logic [ogha_pkg::RC_W-1:0]           cell_row,
	output logic [ogha_pkg::RC_W-1:0]           cell_col,
	output logic [ogha_pkg::COUNT_W-1:0]        cell_count
);

	localparam int DEPTH  = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = ogha_pkg::CELL_W;
	localparam int RCW    = ogha_pkg::RC_W;
	localparam int MW     = ogha_pkg::MUL_W;

	localparam logic [ADDR_W-1:0]     CLR_LAST  = ADDR_W'(DEPTH - 1);
	localparam logic signed [CW-1:0]  HALF_ROWS = CW'(GRID_ROWS / 2);
	localparam logic signed [CW-1:0]  HALF_COLS = CW'(GRID_COLS / 2);
	localparam logic signed [CW-1:0]  ROWS_LIM  = CW'(GRID_ROWS);
	localparam logic signed [CW-1:0]  COLS_LIM  = CW'(GRID_COLS);
	localparam logic signed [MW-1:0]  COLS_MUL  = MW'(GRID_COLS);

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_ROT0, S_ROT1, S_ROT2, S_ROT3, S_ROT4, S_ROT5,
		S_SCL0, S_SCL1, S_SCL2, S_SCL3, S_SCL4, S_SCL5,
		S_RANGE,
		S_ADR0, S_ADR1, S_ADR2,
		S_RD,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [15:0] cos_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] vn_q;
	logic signed [14:0] ve_q;
	logic signed [12:0] fo_q;
	logic [15:0]        cpm_q;

	// item datapath
	logic                              cmd_q;
	logic signed [ogha_pkg::F_W-1:0]   f_q;
	logic signed [15:0]                l_q;
	logic signed [ogha_pkg::ROT_W-1:0] n_q;
	logic signed [ogha_pkg::ROT_W-1:0] e_q;
	logic signed [CW-1:0]              row_q;
	logic signed [CW-1:0]              col_q;
	logic [ADDR_W-1:0]                 addr_q;
	logic [ADDR_W-1:0]                 clr_q;

	// pending result and output register
	logic [ogha_pkg::STAT_W-1:0]  res_status_q;
	logic [RCW-1:0]               res_row_q;
	logic [RCW-1:0]               res_col_q;
	logic [ogha_pkg::COUNT_W-1:0] res_count_q;
	logic                         out_valid_q;
	logic [ogha_pkg::STAT_W-1:0]  status_q;
	logic [RCW-1:0]               cell_row_q;
	logic [RCW-1:0]               cell_col_q;
	logic [ogha_pkg::COUNT_W-1:0] cell_count_q;

	// shared unit and grid memory
	ogha_pkg::mac_op_t                 mac_op;
	logic signed [ogha_pkg::ACC_W-1:0] acc;
	logic signed [ogha_pkg::ACC_W-1:0] acc_adj;
	logic signed [ogha_pkg::ACC_W-1:0] acc_shr;
	logic signed [CW-1:0]              cells;
	logic                              ram_we;
	logic [ADDR_W-1:0]                 ram_waddr;
	logic [ogha_pkg::COUNT_W-1:0]      ram_wdata;
	logic [ogha_pkg::COUNT_W-1:0]      ram_rdata;

	logic veh_out;
	logic in_grid;
	logic signed [ogha_pkg::F_W-1:0] f_nxt;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign cell_row   = cell_row_q;
	assign cell_col   = cell_col_q;
	assign cell_count = cell_count_q;

	// vehicle outside the mapped area disables counting
	assign veh_out = (vn_q > ogha_pkg::VN_LIMIT) || (vn_q < -ogha_pkg::VN_LIMIT) ||
	                 (ve_q > ogha_pkg::VE_LIMIT) || (ve_q < -ogha_pkg::VE_LIMIT);

	assign f_nxt = ogha_pkg::F_W'(point_forward) + ogha_pkg::F_W'(fo_q);

	// truncation toward zero of acc / 2^30: bias negative values before the shift
	assign acc_adj = acc[ogha_pkg::ACC_W-1] ? (acc + ogha_pkg::SCALE_BIAS) : acc;
	assign acc_shr = acc_adj >>> ogha_pkg::SCALE_SHIFT;
	assign cells   = signed'(acc_shr[CW-1:0]);

	assign in_grid = !row_q[CW-1] && (row_q < ROWS_LIM) &&
	                 !col_q[CW-1] && (col_q < COLS_LIM);

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= ogha_pkg::HEADING_COS_RST;
			sin_q <= '0;
			vn_q  <= '0;
			ve_q  <= '0;
			fo_q  <= '0;
			cpm_q <= ogha_pkg::CPM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ogha_pkg::CFG_HEADING_COS:     cos_q <= signed'(cfg_data);
				ogha_pkg::CFG_HEADING_SIN:     sin_q <= signed'(cfg_data);
				ogha_pkg::CFG_VEHICLE_NORTH:   vn_q  <= signed'(cfg_data);
				ogha_pkg::CFG_VEHICLE_EAST:    ve_q  <= signed'(cfg_data[14:0]);
				ogha_pkg::CFG_FORWARD_OFFSET:  fo_q  <= signed'(cfg_data[12:0]);
				ogha_pkg::CFG_CELLS_PER_METER: cpm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand selection for the shared multiply-accumulate unit
	// north = cos*f - sin*l + vn*2^14, east = sin*f + cos*l + ve*2^14,
	// then each is scaled by cells_per_meter in two 17-bit halves
	always_comb begin
		mac_op.en   = 1'b1;
		mac_op.kind = ogha_pkg::MAC_FIRST;
		mac_op.a    = '0;
		mac_op.b    = '0;
		unique case (state_q)
			S_ROT0: begin
				mac_op.a = MW'(cos_q);
				mac_op.b = MW'(f_q);
			end
			S_ROT1: begin
				mac_op.kind = ogha_pkg::MAC_SUB;
				mac_op.a    = MW'(sin_q);
				mac_op.b    = MW'(l_q);
			end
			S_ROT2: begin
				mac_op.kind = ogha_pkg::MAC_ADD;
				mac_op.a    = MW'(vn_q);
				mac_op.b    = ogha_pkg::MUL_POS_Q14;
			end
			S_ROT3: begin
				mac_op.a = MW'(sin_q);
				mac_op.b = MW'(f_q);
			end
			S_ROT4: begin
				mac_op.kind = ogha_pkg::MAC_ADD;
				mac_op.a    = MW'(cos_q);
				mac_op.b    = MW'(l_q);
			end
			S_ROT5: begin
				mac_op.kind = ogha_pkg::MAC_ADD;
				mac_op.a    = MW'(ve_q);
				mac_op.b    = ogha_pkg::MUL_POS_Q14;
			end
			S_SCL0: begin
				mac_op.a = MW'(signed'(n_q[ogha_pkg::ROT_W-1:ogha_pkg::SPLIT]));
				mac_op.b = MW'(cpm_q);
			end
			S_SCL1: begin
				mac_op.kind = ogha_pkg::MAC_SHADD;
				mac_op.a    = MW'(n_q[ogha_pkg::SPLIT-1:0]);
				mac_op.b    = MW'(cpm_q);
			end
			S_SCL2: begin
				mac_op.a = MW'(signed'(e_q[ogha_pkg::ROT_W-1:ogha_pkg::SPLIT]));
				mac_op.b = MW'(cpm_q);
			end
			S_SCL3: begin
				mac_op.kind = ogha_pkg::MAC_SHADD;
				mac_op.a    = MW'(e_q[ogha_pkg::SPLIT-1:0]);
				mac_op.b    = MW'(cpm_q);
			end
			// cell address = row * GRID_COLS + col
			S_RANGE: begin
				mac_op.en = in_grid;
				mac_op.a  = signed'(row_q[MW-1:0]);
				mac_op.b  = COLS_MUL;
			end
			S_ADR0: begin
				mac_op.kind = ogha_pkg::MAC_ADD;
				mac_op.a    = signed'(col_q[MW-1:0]);
				mac_op.b    = ogha_pkg::MUL_ONE;
			end
			default: mac_op.en = 1'b0;
		endcase
	end

	ogha_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	// grid writes: zero during the clearing pass, increment a point's cell after its read unless saturated
	assign ram_we    = (state_q == S_CLEAR) ||
	                   ((state_q == S_RD) && (cmd_q == ogha_pkg::CMD_ACCUM) &&
	                    (ram_rdata != ogha_pkg::COUNT_MAX));
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : (ram_rdata + 1'b1);

	ogha_ram #(
		.WIDTH (ogha_pkg::COUNT_W),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (acc[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			cmd_q <= command;
			f_q   <= f_nxt;
			l_q   <= point_lateral;
			row_q <= CW'(read_row);
			col_q <= CW'(read_col);
		end
		if (state_q == S_ROT4) begin
			n_q <= acc[ogha_pkg::ROT_W-1:0];
		end
		if (state_q == S_SCL1) begin
			e_q <= acc[ogha_pkg::ROT_W-1:0];
		end
		if (state_q == S_SCL3) begin
			row_q <= HALF_ROWS - cells;
		end
		if (state_q == S_SCL5) begin
			col_q <= HALF_COLS + cells;
		end
		if (state_q == S_ADR2) begin
			addr_q <= acc[ADDR_W-1:0];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= '0;
			cell_row_q   <= '0;
			cell_col_q   <= '0;
			cell_count_q <= '0;
			res_status_q <= '0;
			res_row_q    <= '0;
			res_col_q    <= '0;
			res_count_q  <= '0;
		end else begin
			// in S_DONE the output register is handled below
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (command == ogha_pkg::CMD_READ) begin
							state_q <= S_RANGE;
						end else if (veh_out) begin
							res_status_q <= ogha_pkg::STAT_OUTSIDE;
							res_row_q    <= '0;
							res_col_q    <= '0;
							res_count_q  <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_ROT0;
						end
					end
				end
				S_ROT0:  state_q <= S_ROT1;
				S_ROT1:  state_q <= S_ROT2;
				S_ROT2:  state_q <= S_ROT3;
				S_ROT3:  state_q <= S_ROT4;
				S_ROT4:  state_q <= S_ROT5;
				S_ROT5:  state_q <= S_SCL0;
				S_SCL0:  state_q <= S_SCL1;
				S_SCL1:  state_q <= S_SCL2;
				S_SCL2:  state_q <= S_SCL3;
				S_SCL3:  state_q <= S_SCL4;
				S_SCL4:  state_q <= S_SCL5;
				S_SCL5:  state_q <= S_RANGE;
				S_RANGE: begin
					if (in_grid) begin
						state_q <= S_ADR0;
					end else begin
						// a read echoes its position, a point reports none
						res_status_q <= ogha_pkg::STAT_OUTSIDE;
						res_row_q    <= (cmd_q == ogha_pkg::CMD_READ) ? row_q[RCW-1:0] : '0;
						res_col_q    <= (cmd_q == ogha_pkg::CMD_READ) ? col_q[RCW-1:0] : '0;
						res_count_q  <= '0;
						state_q      <= S_DONE;
					end
				end
				S_ADR0:  state_q <= S_ADR1;
				S_ADR1:  state_q <= S_ADR2;
				S_ADR2:  state_q <= S_RD;
				S_RD: begin
					res_row_q <= row_q[RCW-1:0];
					res_col_q <= col_q[RCW-1:0];
					if (cmd_q == ogha_pkg::CMD_READ) begin
						res_status_q <= ogha_pkg::STAT_READ;
						res_count_q  <= ram_rdata;
					end else if (ram_rdata == ogha_pkg::COUNT_MAX) begin
						res_status_q <= ogha_pkg::STAT_SATURATED;
						res_count_q  <= ogha_pkg::COUNT_MAX;
					end else begin
						res_status_q <= ogha_pkg::STAT_COUNTED;
						res_count_q  <= ram_rdata + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// wait for the output register to free up
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						cell_row_q   <= res_row_q;
						cell_col_q   <= res_col_q;
						cell_count_q <= res_count_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no result can appear before the grid is cleared
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !out_valid_q)
		else $error("result valid during clearing pass");

	// an input transfer starts the sequencer
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after input transfer");

	// an increment never writes zero back into the grid
	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q != S_CLEAR)) |-> (ram_wdata != '0))
		else $error("cell count wrapped");

	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ogha_pkg::STAT_COUNTED)) |-> (cell_count_q != '0))
		else $error("counted result with zero count");

	a_saturated_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ogha_pkg::STAT_SATURATED)) |->
		(cell_count_q == ogha_pkg::COUNT_MAX))
		else $error("saturated result without full count");

endmodule

@@ sv/ogha_ram.sv @@
module ogha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/ogha_mac.sv @@
module ogha_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ogha_pkg::mac_op_t                   op,
	output logic signed [ogha_pkg::ACC_W-1:0]   acc
);

	localparam int PROD_W = 2 * ogha_pkg::MUL_W;

	logic                              en_s1;
	ogha_pkg::mac_kind_t               kind_s1;
	logic signed [PROD_W-1:0]          prod_s1;
	logic signed [ogha_pkg::ACC_W-1:0] prod_ext;
	logic signed [ogha_pkg::ACC_W-1:0] acc_nxt;
	logic signed [ogha_pkg::ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= op.en;
		end
	end

	// multiplier register, then accumulate
	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_s1 <= op.a * op.b;
			kind_s1 <= op.kind;
		end
		if (en_s1) begin
			acc_q <= acc_nxt;
		end
	end

	always_comb begin
		prod_ext = {{(ogha_pkg::ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		unique case (kind_s1)
			ogha_pkg::MAC_FIRST: acc_nxt = prod_ext;
			ogha_pkg::MAC_ADD:   acc_nxt = acc_q + prod_ext;
			ogha_pkg::MAC_SUB:   acc_nxt = acc_q - prod_ext;
			ogha_pkg::MAC_SHADD: acc_nxt = (acc_q <<< ogha_pkg::SPLIT) + prod_ext;
			default:             acc_nxt = prod_ext;
		endcase
	end

	assign acc = acc_q;

endmodule
